@@ rtl/grb_pkg.sv @@
// ----------------------------------------------------------------------------
// grb_pkg
// Shared types and codes for the glyph run blitter: opcodes, register
// indexes, cursor/glyph state, configuration and frame-buffer write records.
// ----------------------------------------------------------------------------
package grb_pkg;

    localparam int MAX_WRITES = 4;
    localparam int COUNT_W    = 3;
    localparam int ADDR_W     = 12;

    localparam logic [1:0] OP_SET_CURSOR = 2'd0;
    localparam logic [1:0] OP_RAW_WRITE  = 2'd1;
    localparam logic [1:0] OP_GLYPH_BYTE = 2'd2;

    localparam logic [1:0] CFG_INVERT_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_INVERT_MASK    = 2'd1;
    localparam logic [1:0] CFG_BASELINE_SHIFT = 2'd2;

    localparam logic [4:0] RUN_MASK = 5'h1F;

    typedef struct packed {
        logic [3:0] row;
        logic [7:0] column;
        logic       glyph_active;
        logic [4:0] glyph_span;
        logic [2:0] pages_left;
        logic [4:0] bytes_in_page;
        logic [1:0] height_minus_one;
    } cursor_state_t;

    typedef struct packed {
        logic       invert_enable;
        logic [7:0] invert_mask;
        logic [3:0] baseline_shift;
    } blit_cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [7:0]        data;
        logic              in_range;
        logic              last;
    } write_t;

    typedef write_t [MAX_WRITES-1:0] write_vec_t;

endpackage

@@ rtl/glyph_run_blitter_top.sv @@
// ----------------------------------------------------------------------------
// glyph_run_blitter_top
// Turns a byte stream of cursor moves, raw bytes and glyph records into
// frame-buffer byte writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one request per byte: set cursor, raw byte write or
//   glyph record byte (header or data). Output channel (m_*): one frame-buffer
//   write per beat with address, data, in-range flag and last, where last
//   marks the final write caused by a request.
//   cfg_we/cfg_index/cfg_wdata write invert enable, invert mask and baseline
//   shift; write them only while the block is idle.
//   A request is decoded in the cycle it is accepted; its writes are loaded
//   into a four-entry write buffer and appear on m_* in the cycle after.
//   Throughput: one request per cycle while each request makes at most one
//   write and m_ready is high. A glyph byte closing a page makes two writes
//   and an empty-run header makes one to four; the next request then waits
//   until the buffer is down to its final write. A request causing no write
//   (cursor set, glyph header with nonzero run) leaves the buffer empty.
//   Reset clears the cursor, glyph progress, registers and write buffer.
//   When m_ready is low the current write holds and s_ready stays low while
//   any write is pending.
// ----------------------------------------------------------------------------
module glyph_run_blitter_top #(
    parameter int BUFFER_WIDTH = 128,
    parameter int BUFFER_ROWS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [7:0]  s_data_byte,
    input  logic [3:0]  s_cursor_row,
    input  logic [7:0]  s_cursor_column,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_write_address,
    output logic [7:0]  m_write_data,
    output logic        m_in_range,
    output logic        m_last
);

    grb_pkg::cursor_state_t state_reg, state_next, step_state;
    grb_pkg::blit_cfg_t     cfg_reg, cfg_next;
    grb_pkg::write_vec_t    entry_reg, entry_next, step_writes;
    logic [grb_pkg::COUNT_W-1:0] count_reg, count_next, step_count;

    logic accept;
    logic pop;

    grb_step #(
        .BUFFER_WIDTH (BUFFER_WIDTH),
        .BUFFER_ROWS  (BUFFER_ROWS)
    ) u_step (
        .op            (s_op),
        .data_byte     (s_data_byte),
        .cursor_row    (s_cursor_row),
        .cursor_column (s_cursor_column),
        .state_cur     (state_reg),
        .cfg           (cfg_reg),
        .state_nxt     (step_state),
        .writes        (step_writes),
        .write_count   (step_count)
    );

    assign m_valid = (count_reg != '0);
    assign s_ready = (count_reg == '0)
                   || ((count_reg == grb_pkg::COUNT_W'(1)) && m_ready);
    assign accept  = s_valid && s_ready;
    assign pop     = m_valid && m_ready;

    assign m_write_address = entry_reg[0].address;
    assign m_write_data    = entry_reg[0].data;
    assign m_in_range      = entry_reg[0].in_range;
    assign m_last          = entry_reg[0].last;

    always_comb begin
        state_next = state_reg;
        entry_next = entry_reg;
        count_next = count_reg;
        priority if (accept) begin
            state_next = step_state;
            entry_next = step_writes;
            count_next = step_count;
        end else if (pop) begin
            entry_next = entry_reg >> $bits(grb_pkg::write_t);
            count_next = count_reg - grb_pkg::COUNT_W'(1);
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                grb_pkg::CFG_INVERT_ENABLE:  cfg_next.invert_enable  = cfg_wdata[0];
                grb_pkg::CFG_INVERT_MASK:    cfg_next.invert_mask    = cfg_wdata;
                grb_pkg::CFG_BASELINE_SHIFT: cfg_next.baseline_shift = cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            cfg_reg   <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            cfg_reg   <= cfg_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

@@ rtl/grb_step.sv @@
// ----------------------------------------------------------------------------
// grb_step
// Single-pass decode of one request: computes the frame-buffer writes it
// causes (up to four) and the cursor/glyph state that follows it.
// ----------------------------------------------------------------------------
module grb_step #(
    parameter int BUFFER_WIDTH = 128,
    parameter int BUFFER_ROWS  = 16
) (
    input  logic [1:0]             op,
    input  logic [7:0]             data_byte,
    input  logic [3:0]             cursor_row,
    input  logic [7:0]             cursor_column,
    input  grb_pkg::cursor_state_t state_cur,
    input  grb_pkg::blit_cfg_t     cfg,
    output grb_pkg::cursor_state_t state_nxt,
    output grb_pkg::write_vec_t    writes,
    output logic [grb_pkg::COUNT_W-1:0] write_count
);

    localparam logic [grb_pkg::ADDR_W-1:0] WIDTH_A = grb_pkg::ADDR_W'(BUFFER_WIDTH);
    localparam logic [8:0]                 WIDTH_C = 9'(BUFFER_WIDTH);
    localparam logic [4:0]                 ROWS_C  = 5'(BUFFER_ROWS);

    function automatic grb_pkg::write_t make_write(
        input logic [3:0] row,
        input logic [7:0] column,
        input logic [7:0] data,
        input logic       last
    );
        grb_pkg::write_t w;
        w.address  = {{(grb_pkg::ADDR_W-4){1'b0}}, row} * WIDTH_A
                   + {{(grb_pkg::ADDR_W-8){1'b0}}, column};
        w.data     = data;
        w.in_range = ({1'b0, row} < ROWS_C) && ({1'b0, column} < WIDTH_C);
        w.last     = last;
        return w;
    endfunction

    logic [7:0] spacer;
    logic [7:0] shifted;
    logic [7:0] glyph_data;
    logic [4:0] hdr_run;
    logic [1:0] hdr_height;
    logic [4:0] bytes_inc;
    logic [2:0] pages_dec;

    assign spacer     = cfg.invert_enable ? cfg.invert_mask : 8'h00;
    assign shifted    = cfg.baseline_shift[3] ? 8'h00 : (data_byte >> cfg.baseline_shift[2:0]);
    assign glyph_data = cfg.invert_enable ? (~shifted & cfg.invert_mask) : shifted;
    assign hdr_run    = data_byte[4:0] & grb_pkg::RUN_MASK;
    assign hdr_height = data_byte[7:6];
    assign bytes_inc  = state_cur.bytes_in_page + 5'd1;
    assign pages_dec  = state_cur.pages_left - 3'd1;

    always_comb begin
        state_nxt   = state_cur;
        writes      = '0;
        write_count = '0;
        unique case (op)
            grb_pkg::OP_SET_CURSOR: begin
                state_nxt.row    = cursor_row;
                state_nxt.column = cursor_column;
            end
            grb_pkg::OP_RAW_WRITE: begin
                writes[0]        = make_write(state_cur.row, state_cur.column, data_byte, 1'b1);
                write_count      = grb_pkg::COUNT_W'(1);
                state_nxt.column = state_cur.column + 8'd1;
            end
            grb_pkg::OP_GLYPH_BYTE: begin
                if (!state_cur.glyph_active) begin
                    if (hdr_run != 5'd0) begin
                        state_nxt.glyph_active     = 1'b1;
                        state_nxt.glyph_span       = hdr_run;
                        state_nxt.pages_left       = {1'b0, hdr_height} + 3'd1;
                        state_nxt.bytes_in_page    = 5'd0;
                        state_nxt.height_minus_one = hdr_height;
                    end else begin
                        // empty glyph: one spacer per page, same column
                        for (int p = 0; p < grb_pkg::MAX_WRITES; p++) begin
                            if (2'(p) <= hdr_height) begin
                                writes[p] = make_write(state_cur.row + 4'(p), state_cur.column,
                                                       spacer, 2'(p) == hdr_height);
                            end
                        end
                        write_count      = {1'b0, hdr_height} + grb_pkg::COUNT_W'(1);
                        state_nxt.column = state_cur.column + 8'd1;
                    end
                end else begin
                    if (bytes_inc == state_cur.glyph_span) begin
                        writes[0] = make_write(state_cur.row, state_cur.column,
                                               glyph_data, 1'b0);
                        writes[1] = make_write(state_cur.row, state_cur.column + 8'd1,
                                               spacer, 1'b1);
                        write_count             = grb_pkg::COUNT_W'(2);
                        state_nxt.pages_left    = pages_dec;
                        state_nxt.bytes_in_page = 5'd0;
                        if (pages_dec != 3'd0) begin
                            state_nxt.row    = state_cur.row + 4'd1;
                            state_nxt.column = state_cur.column + 8'd1
                                             - {3'b000, state_cur.glyph_span};
                        end else begin
                            state_nxt.row          = state_cur.row
                                                   - {2'b00, state_cur.height_minus_one};
                            state_nxt.column       = state_cur.column + 8'd2;
                            state_nxt.glyph_active = 1'b0;
                        end
                    end else begin
                        writes[0] = make_write(state_cur.row, state_cur.column,
                                               glyph_data, 1'b1);
                        write_count             = grb_pkg::COUNT_W'(1);
                        state_nxt.bytes_in_page = bytes_inc;
                        state_nxt.column        = state_cur.column + 8'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/grb_checker.sv @@
// ----------------------------------------------------------------------------
// grb_checker
// Port-level checks on the glyph run blitter, bound to the top level.
// ----------------------------------------------------------------------------
module grb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [11:0] m_write_address,
    input logic [7:0]  m_write_data,
    input logic        m_in_range,
    input logic        m_last
);

    // write buffer empties on reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("write pending after reset");

    // empty buffer always takes a request
    assert property (@(posedge aclk) disable iff (!aresetn) !m_valid |-> s_ready)
        else $error("input stalled with empty write buffer");

    // a burst is not interrupted by new requests and never ends early
    assert property (@(posedge aclk) disable iff (!aresetn) m_valid && !m_last |-> !s_ready)
        else $error("request taken in the middle of a write burst");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("write burst ended without last");

    // stalled write holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_write_address)
                             && $stable(m_write_data) && $stable(m_in_range)
                             && $stable(m_last))
        else $error("stalled write changed");

endmodule

bind glyph_run_blitter_top grb_checker u_grb_checker (.*);
